/* src/nqfs_pkg.sv */
// Package for the N-queens first-solution searcher.
// Holds the microcode word, step numbers, jump conditions and the control store.
// No dependencies.
`timescale 1ns / 1ps

package nqfs_pkg;

    // Internal width of row, column and index values.
    // Holds board sizes up to 32 plus one overflow candidate.
    localparam int CW = 6;
    localparam int FW = 5;  // width of the row/column/size fields

    typedef logic [3:0] t_step;

    localparam t_step S_IDLE   = 4'd0;
    localparam t_step S_INC    = 4'd1;
    localparam t_step S_CHK    = 4'd2;
    localparam t_step S_CMP    = 4'd3;
    localparam t_step S_OK     = 4'd4;
    localparam t_step S_BACK   = 4'd5;
    localparam t_step S_POP    = 4'd6;
    localparam t_step S_EINIT  = 4'd7;
    localparam t_step S_EISSUE = 4'd8;
    localparam t_step S_ELOAD  = 4'd9;
    localparam t_step S_FAIL   = 4'd10;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_START,
        C_OVER,
        C_I_EQ_ROW,
        C_CONFLICT,
        C_ROW_EQ_N,
        C_ROW_ONE,
        C_OFREE,
        C_I_EQ_N
    } t_cond;

    typedef struct packed {
        t_cond cond;
        t_step tgt_t;
        t_step tgt_f;
        logic  start_init;
        logic  col_inc;
        logic  i_one;
        logic  i_inc;
        logic  rd_back;
        logic  mem_wr;
        logic  row_inc;
        logic  row_dec;
        logic  col_clr;
        logic  col_ld_mem;
        logic  out_sol;
        logic  out_fail;
    } t_uword;

    typedef struct packed {
        logic start;
        logic over;
        logic i_eq_row;
        logic conflict;
        logic row_eq_n;
        logic row_one;
        logic ofree;
        logic i_eq_n;
    } t_status;

    // Control store.
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        w = '0;
        w.cond  = C_ALWAYS;
        w.tgt_t = S_IDLE;
        w.tgt_f = S_IDLE;
        case (s)
            S_IDLE: begin
                w.cond = C_START;  w.tgt_t = S_INC;    w.tgt_f = S_IDLE;
                w.start_init = 1'b1;
            end
            S_INC: begin
                w.cond = C_OVER;   w.tgt_t = S_BACK;   w.tgt_f = S_CHK;
                w.col_inc = 1'b1;  w.i_one = 1'b1;
            end
            S_CHK: begin
                w.cond = C_I_EQ_ROW; w.tgt_t = S_OK;   w.tgt_f = S_CMP;
            end
            S_CMP: begin
                w.cond = C_CONFLICT; w.tgt_t = S_INC;  w.tgt_f = S_CHK;
                w.i_inc = 1'b1;
            end
            S_OK: begin
                w.cond = C_ROW_EQ_N; w.tgt_t = S_EINIT; w.tgt_f = S_INC;
                w.mem_wr = 1'b1;   w.row_inc = 1'b1;   w.col_clr = 1'b1;
            end
            S_BACK: begin
                w.cond = C_ROW_ONE; w.tgt_t = S_FAIL;  w.tgt_f = S_POP;
                w.row_dec = 1'b1;  w.rd_back = 1'b1;
            end
            S_POP: begin
                w.cond = C_ALWAYS; w.tgt_t = S_INC;    w.tgt_f = S_INC;
                w.col_ld_mem = 1'b1;
            end
            S_EINIT: begin
                w.cond = C_ALWAYS; w.tgt_t = S_EISSUE; w.tgt_f = S_EISSUE;
                w.i_one = 1'b1;
            end
            S_EISSUE: begin
                w.cond = C_OFREE;  w.tgt_t = S_ELOAD;  w.tgt_f = S_EISSUE;
            end
            S_ELOAD: begin
                w.cond = C_I_EQ_N; w.tgt_t = S_IDLE;   w.tgt_f = S_EISSUE;
                w.out_sol = 1'b1;  w.i_inc = 1'b1;
            end
            S_FAIL: begin
                w.cond = C_OFREE;  w.tgt_t = S_IDLE;   w.tgt_f = S_FAIL;
                w.out_fail = 1'b1;
            end
            default: begin
                w.cond = C_ALWAYS; w.tgt_t = S_IDLE;   w.tgt_f = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* src/nqfs_datapath.sv */
// Datapath of the N-queens searcher: row, candidate column, check index,
// column stack memory and the diagonal/column conflict test.
// Depends on nqfs_pkg.
`timescale 1ns / 1ps

module nqfs_datapath import nqfs_pkg::*; #(
    parameter int MAX_BOARD = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_uword        i_uw,
    input  logic          i_start,
    input  logic [FW-1:0] i_board_size,
    input  logic          i_ofree,
    output t_status       o_st,
    output logic          o_out_ld,
    output logic [FW-1:0] o_out_row,
    output logic [FW-1:0] o_out_col,
    output logic          o_out_found,
    output logic          o_out_last
);

    localparam int AW = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;
    localparam logic [CW-1:0] MAXB = CW'(MAX_BOARD);

    logic [CW-1:0] r_row, r_col, r_i, r_n, r_rd;
    logic [CW-1:0] n_row, n_col, n_i, n_n;
    logic [CW-1:0] mem [MAX_BOARD];
    logic [CW-1:0] col_next, bs_ext, dc, dd, rd_idx, wr_idx;
    logic [AW-1:0] rd_addr, wr_addr;

    assign bs_ext   = CW'(i_board_size);
    assign col_next = r_col + CW'(1);
    assign dc       = (r_rd > r_col) ? (r_rd - r_col) : (r_col - r_rd);
    assign dd       = r_row - r_i;
    assign rd_idx   = i_uw.rd_back ? (r_row - CW'(2)) : (r_i - CW'(1));
    assign wr_idx   = r_row - CW'(1);
    assign rd_addr  = rd_idx[AW-1:0];
    assign wr_addr  = wr_idx[AW-1:0];

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        n_i   = r_i;
        n_n   = r_n;
        if (i_start && i_uw.start_init) begin
            n_row = CW'(1);
            n_col = '0;
            if (bs_ext == '0) begin
                n_n = CW'(1);
            end else if (bs_ext > MAXB) begin
                n_n = MAXB;
            end else begin
                n_n = bs_ext;
            end
        end
        if (i_uw.col_inc)    n_col = col_next;
        if (i_uw.col_clr)    n_col = '0;
        if (i_uw.col_ld_mem) n_col = r_rd;
        if (i_uw.i_one)      n_i   = CW'(1);
        if (i_uw.i_inc)      n_i   = r_i + CW'(1);
        if (i_uw.row_inc)    n_row = r_row + CW'(1);
        if (i_uw.row_dec)    n_row = r_row - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_i   <= '0;
            r_n   <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
            r_i   <= n_i;
            r_n   <= n_n;
        end
    end

    // Column stack: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_uw.mem_wr) begin
            mem[wr_addr] <= r_col;
        end
        r_rd <= mem[rd_addr];
    end

    always_comb begin
        o_st          = '0;
        o_st.start    = i_start;
        o_st.over     = (col_next > r_n);
        o_st.i_eq_row = (r_i == r_row);
        o_st.conflict = (dc == '0) || (dc == dd);
        o_st.row_eq_n = (r_row == r_n);
        o_st.row_one  = (r_row == CW'(1));
        o_st.ofree    = i_ofree;
        o_st.i_eq_n   = (r_i == r_n);
    end

    assign o_out_ld    = (i_uw.out_sol || i_uw.out_fail) && i_ofree;
    assign o_out_row   = i_uw.out_sol ? r_i[FW-1:0] : '0;
    assign o_out_col   = i_uw.out_sol ? r_rd[FW-1:0] : '0;
    assign o_out_found = i_uw.out_sol;
    assign o_out_last  = i_uw.out_fail || (r_i == r_n);

endmodule

/* src/n_queens_first_solution.sv */
// Search: a request is taken at idle; each candidate column is stepped in, then checked
// against each earlier row in turn and placed if none conflicts; an exhausted row backs up.
// Output: a setup step, then one row beat at a time, each issued once the output register
// is free; with no placement one beat leaves from the fail step once it is free. Total time
// follows the search path. One search at a time: a new request is taken once the sequencer
// is back at idle. Synchronous active-low reset: board size 8, sequencer idle, no beat.
`timescale 1ns / 1ps

module n_queens_first_solution import nqfs_pkg::*; #(
    parameter int MAX_BOARD = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [FW-1:0] i_cfg_wdata,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_start_req,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [FW-1:0] o_row,
    output logic [FW-1:0] o_column,
    output logic          o_found,
    output logic          o_last
);

    logic [FW-1:0] r_board_size;
    t_step         r_step, n_step;
    t_uword        uw;
    t_status       st;
    logic          cond_hit, ofree, start;
    logic          out_ld, out_found, out_last;
    logic [FW-1:0] out_row, out_col;
    logic          r_o_valid;
    logic [FW-1:0] r_o_row, r_o_col;
    logic          r_o_found, r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_size <= FW'(8);
        end else if (i_cfg_we) begin
            r_board_size <= i_cfg_wdata;
        end
    end

    assign o_ready = (r_step == S_IDLE);
    assign start   = i_valid && o_ready && i_start_req;
    assign ofree   = !r_o_valid || i_ready;
    assign uw      = ucode(r_step);

    nqfs_datapath #(
        .MAX_BOARD (MAX_BOARD)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_uw         (uw),
        .i_start      (start),
        .i_board_size (r_board_size),
        .i_ofree      (ofree),
        .o_st         (st),
        .o_out_ld     (out_ld),
        .o_out_row    (out_row),
        .o_out_col    (out_col),
        .o_out_found  (out_found),
        .o_out_last   (out_last)
    );

    always_comb begin
        case (uw.cond)
            C_ALWAYS:   cond_hit = 1'b1;
            C_START:    cond_hit = st.start;
            C_OVER:     cond_hit = st.over;
            C_I_EQ_ROW: cond_hit = st.i_eq_row;
            C_CONFLICT: cond_hit = st.conflict;
            C_ROW_EQ_N: cond_hit = st.row_eq_n;
            C_ROW_ONE:  cond_hit = st.row_one;
            C_OFREE:    cond_hit = st.ofree;
            C_I_EQ_N:   cond_hit = st.i_eq_n;
            default:    cond_hit = 1'b1;
        endcase
        n_step = cond_hit ? uw.tgt_t : uw.tgt_f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // Output beat register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_ld) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ld) begin
            r_o_row   <= out_row;
            r_o_col   <= out_col;
            r_o_found <= out_found;
            r_o_last  <= out_last;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_row    = r_o_row;
    assign o_column = r_o_col;
    assign o_found  = r_o_found;
    assign o_last   = r_o_last;

endmodule

/* bench/testbench.sv */
// Self-checking bench for n_queens_first_solution: board sizes written through the config
// port, search requests driven as valid/ready beats, every result beat checked in order.
// Depends on nqfs_pkg and n_queens_first_solution from src.
`timescale 1ns / 1ps

module testbench import nqfs_pkg::*; ();

    localparam int MAX_N  = 16;
    localparam int SETTLE = 20;

    typedef struct packed {
        logic [FW-1:0] row;
        logic [FW-1:0] column;
        logic          found;
        logic          last;
    } t_queen_beat;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic [FW-1:0] i_cfg_wdata = '0;
    logic          i_valid = 1'b0;
    logic          o_ready;
    logic          i_start_req = 1'b0;
    logic          o_valid;
    logic          i_ready = 1'b0;
    logic [FW-1:0] o_row;
    logic [FW-1:0] o_column;
    logic          o_found;
    logic          o_last;

    logic          start_q[$];
    t_queen_beat   placement_q[$];

    logic [FW-1:0] board_cfg = 5'd8;
    int            queen_cols[MAX_N];
    int            search_depth;
    bit            search_solved;

    int send_idle, recv_idle;
    int beats_sent, beats_in;
    int stall_asks, stall_served, stall_left;
    int err_count, beats_checked, searches, no_place, ignored;

    n_queens_first_solution #(.MAX_BOARD(16)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_start_req (i_start_req),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_row       (o_row),
        .o_column    (o_column),
        .o_found     (o_found),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    task automatic log_mismatch(input string msg);
        err_count++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            log_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // Depth-first search for the first placement, columns tried in ascending order.
    function automatic void solve_queens(input logic [FW-1:0] size_reg);
        int  n, r, d;
        bit  clash;
        t_queen_beat b;
        n = size_reg;
        if (n == 0) n = 1;
        if (n > MAX_N) n = MAX_N;
        search_solved = 1'b0;
        r = 1;
        queen_cols[0] = 0;
        while (1) begin
            queen_cols[r-1]++;
            if (queen_cols[r-1] > n) begin
                r--;
                if (r == 0) break;
                continue;
            end
            clash = 1'b0;
            for (int i = 1; i < r; i++) begin
                d = queen_cols[i-1] - queen_cols[r-1];
                if (d < 0) d = -d;
                if (d == 0 || d == r - i) clash = 1'b1;
            end
            if (!clash) begin
                if (r == n) begin
                    search_solved = 1'b1;
                    break;
                end
                r++;
                queen_cols[r-1] = 0;
            end
        end
        search_depth = r;
        if (!search_solved) begin
            b = '{row: '0, column: '0, found: 1'b0, last: 1'b1};
            placement_q = {placement_q, b};
            no_place++;
        end else begin
            for (int k = 1; k <= n; k++) begin
                b.row    = k[FW-1:0];
                b.column = queen_cols[k-1][FW-1:0];
                b.found  = 1'b1;
                b.last   = (k == n);
                placement_q = {placement_q, b};
            end
        end
    endfunction

    // Request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || beats_in == beats_sent) begin
            if (start_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                i_valid     <= 1'b1;
                i_start_req <= start_q.pop_front();
                beats_sent++;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Request acceptance and prediction
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            beats_in++;
            if (i_start_req) begin
                searches++;
                solve_queens(board_cfg);
            end else begin
                ignored++;
            end
        end
    end

    // Result ready, with random idling and long hold-offs on request
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (stall_asks != stall_served) begin
            stall_served++;
            stall_left = 600;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_queen_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            if (placement_q.size() == 0) begin
                log_mismatch($sformatf("unexpected beat row %0d column %0d", o_row, o_column));
            end else begin
                want = placement_q.pop_front();
                beats_checked++;
                check_field("row", 8'(o_row), 8'(want.row));
                check_field("column", 8'(o_column), 8'(want.column));
                check_field("found", 8'(o_found), 8'(want.found));
                check_field("last", 8'(o_last), 8'(want.last));
            end
        end
    end

    task automatic set_board(input logic [FW-1:0] size);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= size;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        board_cfg = size;
    endtask

    task automatic drain();
        while (start_q.size() != 0 || beats_in != beats_sent || i_valid
               || placement_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int  pick, cnt, real_reqs;
        logic [FW-1:0] size;
        logic req;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle = 35;
        recv_idle = 87;
        start_q = '{1'b1, 1'b0, 1'b1};
        drain();
        for (int s = 0; s <= 3; s++) begin
            set_board(s[FW-1:0]);
            start_q = {start_q, 1'b1};
            drain();
        end
        set_board(5'd4);
        stall_asks++;
        start_q = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
        drain();
        set_board(5'd5);
        start_q = {start_q, 1'b1};
        drain();
        set_board(5'd16);
        start_q = {start_q, 1'b1};
        drain();
        set_board(5'd31);
        start_q = '{1'b1, 1'b0};
        drain();

        for (int mode = 0; mode < 2; mode++) begin
            send_idle = (mode == 0) ? 87 : 0;
            recv_idle = (mode == 0) ? 35 : 0;
            real_reqs = 0;
            while (real_reqs < 40) begin
                pick = $urandom_range(99);
                if (pick < 10)
                    size = FW'($urandom_range(11, 13));
                else if (pick < 15)
                    size = '0;
                else
                    size = FW'($urandom_range(1, 10));
                set_board(size);
                cnt = $urandom_range(1, 6);
                repeat (cnt) begin
                    req = ($urandom_range(7) != 0);
                    real_reqs += int'(req);
                    start_q = {start_q, req};
                end
                drain();
            end
        end

        $display("Searches run: %0d (%0d with no placement), ignored requests: %0d",
                 searches, no_place, ignored);
        $display("Result beats checked: %0d, mismatches: %0d", beats_checked, err_count);
        if (err_count == 0 && placement_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #(64'd2_000_000_000);
        $display("Timeout with %0d result beats outstanding", placement_q.size());
        $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
src/nqfs_pkg.sv
src/nqfs_datapath.sv
src/n_queens_first_solution.sv
bench/testbench.sv
